### rtl/gsfm_pkg.sv
`default_nettype none

package gsfm_pkg;

    // Width of the kept timestamps; elapsed times wrap modulo 2**TIME_BITS.
    localparam int TIME_BITS = 32;

    // Width that holds both a time and a 32-bit configuration value.
    localparam int WIDE_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    // Width of the scaled values used in the landing compare (times 10 and times 9).
    localparam int LAND_W = WIDE_W + 4;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [WIDE_W-1:0]    wide_t;
    typedef logic [LAND_W-1:0]    land_t;

    // Flight phase thresholds in milliseconds.
    localparam time_t GROUND_LIMIT_MS  = time_t'(500);
    localparam time_t TAKEOFF_LIMIT_MS = time_t'(4000);
    localparam time_t SUSPECT_HOLD_MS  = time_t'(400);

    // Configuration register indexes.
    localparam logic [1:0] CFG_FLIGHT_DURATION = 2'd0;
    localparam logic [1:0] CFG_REACQUIRE_QUIET = 2'd1;
    localparam logic [1:0] CFG_RECOVERY_GATE   = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] FLIGHT_DURATION_RST = 32'd60000;
    localparam logic [31:0] REACQUIRE_QUIET_RST = 32'd2000;
    localparam logic [15:0] RECOVERY_GATE_RST   = 16'd500;

    typedef enum logic [2:0] {
        MODE_GROUNDED  = 3'd0,
        MODE_TAKEOFF   = 3'd1,
        MODE_MISSION   = 3'd2,
        MODE_SUSPECT   = 3'd3,
        MODE_REJECTED  = 3'd4,
        MODE_REACQUIRE = 3'd5,
        MODE_LANDING   = 3'd6
    } mode_t;

    // One input item.
    typedef struct packed {
        logic [31:0] time_ms;
        logic        spoof_detected;
        logic [15:0] residual_cm;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic [2:0] flight_mode;
        logic       gps_ok;
        logic       failsafe;
    } status_t;

    // Configuration as seen by the mode logic; the duration is kept times nine.
    typedef struct packed {
        land_t       land_x9;
        logic [31:0] quiet_ms;
        logic [15:0] gate_cm;
    } cfg_t;

    // State kept from one item to the next.
    typedef struct packed {
        mode_t mode;
        time_t entry_time;
        time_t detect_time;
    } state_t;

endpackage

`default_nettype wire

### rtl/gsfm_cfg_regs.sv
`default_nettype none

module gsfm_cfg_regs
    import gsfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    land_t       land_x9_reg;
    logic [31:0] quiet_reg;
    logic [15:0] gate_reg;
    land_t       dur_ext;

    // The duration is stored times nine so that the landing test needs no divider.
    assign dur_ext = land_t'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            land_x9_reg <= (land_t'(FLIGHT_DURATION_RST) << 3) + land_t'(FLIGHT_DURATION_RST);
            quiet_reg   <= REACQUIRE_QUIET_RST;
            gate_reg    <= RECOVERY_GATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLIGHT_DURATION: land_x9_reg <= (dur_ext << 3) + dur_ext;
                CFG_REACQUIRE_QUIET: quiet_reg   <= cfg_data;
                CFG_RECOVERY_GATE:   gate_reg    <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    assign cfg.land_x9  = land_x9_reg;
    assign cfg.quiet_ms = quiet_reg;
    assign cfg.gate_cm  = gate_reg;

endmodule

`default_nettype wire

### rtl/gsfm_mode_logic.sv
`default_nettype none

module gsfm_mode_logic
    import gsfm_pkg::*;
(
    input  wire state_t  cur,
    input  wire sample_t sample,
    input  wire cfg_t    cfg,
    output state_t       nxt,
    output status_t      status
);

    time_t now;
    land_t now_x10;
    logic  below_gate;
    logic  past_landing;
    mode_t m1;
    time_t e1;
    mode_t m2;
    time_t e2;
    time_t d2;
    mode_t m3;
    time_t e3;
    logic  trusted;
    wide_t since_entry;
    wide_t since_detect;

    assign now        = time_t'(sample.time_ms);
    assign below_gate = sample.residual_cm < cfg.gate_cm;

    // now > floor(9 * duration / 10) holds exactly when 10 * now > 9 * duration.
    assign now_x10      = (land_t'(now) << 3) + (land_t'(now) << 1);
    assign past_landing = now_x10 > cfg.land_x9;

    // Flight phase rules.
    always_comb
    begin
        m1 = cur.mode;
        e1 = cur.entry_time;
        priority if (now < GROUND_LIMIT_MS)
        begin
            if (cur.mode != MODE_GROUNDED)
            begin
                m1 = MODE_GROUNDED;
                e1 = now;
            end
        end
        else if (now < TAKEOFF_LIMIT_MS && cur.mode == MODE_GROUNDED)
        begin
            m1 = MODE_TAKEOFF;
            e1 = now;
        end
        else if (past_landing && cur.mode != MODE_LANDING)
        begin
            m1 = MODE_LANDING;
            e1 = now;
        end
        else
        begin
        end
    end

    // A detection stamps the time and forces suspect unless GPS is already in doubt.
    always_comb
    begin
        m2 = m1;
        e2 = e1;
        d2 = cur.detect_time;
        if (sample.spoof_detected)
        begin
            d2 = now;
            if (m1 != MODE_REJECTED && m1 != MODE_SUSPECT)
            begin
                m2 = MODE_SUSPECT;
                e2 = now;
            end
        end
    end

    // Elapsed times wrap in the time width.
    assign since_entry  = wide_t'(time_t'(now - e2));
    assign since_detect = wide_t'(time_t'(now - d2));

    // Per-mode rules; every move here goes to a different mode.
    always_comb
    begin
        m3      = m2;
        e3      = e2;
        trusted = 1'b1;
        unique case (m2)
            MODE_TAKEOFF:
            begin
                if (now >= TAKEOFF_LIMIT_MS)
                begin
                    m3 = MODE_MISSION;
                    e3 = now;
                end
            end
            MODE_SUSPECT:
            begin
                if (since_entry > wide_t'(SUSPECT_HOLD_MS))
                begin
                    m3 = MODE_REJECTED;
                    e3 = now;
                end
            end
            MODE_REJECTED:
            begin
                trusted = 1'b0;
                if (since_detect > wide_t'(cfg.quiet_ms) && below_gate)
                begin
                    m3 = MODE_REACQUIRE;
                    e3 = now;
                end
            end
            MODE_REACQUIRE:
            begin
                if (below_gate && since_entry > wide_t'(cfg.quiet_ms))
                begin
                    m3 = MODE_MISSION;
                    e3 = now;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign nxt.mode        = m3;
    assign nxt.entry_time  = e3;
    assign nxt.detect_time = d2;

    assign status.flight_mode = m3;
    assign status.gps_ok      = trusted;
    assign status.failsafe    = (m3 == MODE_REJECTED);

endmodule

`default_nettype wire

### rtl/gps_spoof_flight_mode_fsm.sv
`default_nettype none

// Channel  | Handshake                    | Payload
// ---------+------------------------------+--------------------------------------
// sample   | sample_valid / sample_stall  | sample_data: time, detect flag, residual
// status   | status_valid / status_stall  | status_data: mode, trusted, failsafe
// config   | cfg_we                       | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled.
// The item sits in an input register, the mode logic runs in one pass, and the result
// and the new mode state are registered together on the same edge.
// Reset puts the mode at grounded with both stored times at zero.
// A stalled result holds; the input register keeps taking items while it has room.

module gps_spoof_flight_mode_fsm
    import gsfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire sample_t     sample_data,
    output logic             status_valid,
    input  wire logic        status_stall,
    output status_t          status_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    logic    sample_valid_next;
    status_t status_reg;
    status_t status_next;
    logic    status_valid_reg;
    logic    status_valid_next;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;
    logic    take;

    gsfm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gsfm_mode_logic u_logic (
        .cur    (state_reg),
        .sample (sample_reg),
        .cfg    (cfg),
        .nxt    (state_next),
        .status (status_next)
    );

    // Handshake: the held item moves on when the result register is free or draining.
    assign advance           = sample_valid_reg && (!status_valid_reg || !status_stall);
    assign sample_stall      = sample_valid_reg && !advance;
    assign take              = sample_valid && !sample_stall;
    assign sample_valid_next = take || (sample_valid_reg && !advance);
    assign status_valid_next = advance || (status_valid_reg && status_stall);

    // Control state and mode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg      <= 1'b0;
            status_valid_reg      <= 1'b0;
            state_reg.mode        <= MODE_GROUNDED;
            state_reg.entry_time  <= '0;
            state_reg.detect_time <= '0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            status_valid_reg <= status_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample_data;
        end
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign status_valid = status_valid_reg;
    assign status_data  = status_reg;

endmodule

`default_nettype wire
